FILE: rtl/mqse_pkg.sv
package mqse_pkg;

  localparam int GROUP_LEN   = 5;
  localparam int PATTERN_LEN = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int REG_BITS = 16;
  localparam int ADDR_W   = 3;

  localparam logic [REG_BITS-1:0] STEP_RST    = 16'd26214;
  localparam logic [REG_BITS-1:0] PATTERN_RST = 16'd30111;

  // fill and emit counters run 0..GROUP_LEN-1
  localparam int FILL_W = $clog2(GROUP_LEN);
  // group sum and step times group length
  localparam int SUM_W  = SAMPLE_BITS + $clog2(GROUP_LEN);
  localparam int ND_W   = REG_BITS + $clog2(GROUP_LEN);
  // divider magnitude width and signed offset numerator width
  localparam int DIV_W  = ((SUM_W > ND_W) ? SUM_W : ND_W) + 2;
  localparam int X_W    = DIV_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int POS_W  = 4;

  typedef enum logic [0:0] {
    REG_STEP    = 1'b0,
    REG_PATTERN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          region_start;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          group_last;
  } out_word_t;

  typedef struct packed {
    logic [REG_BITS-1:0] step_size;
    logic [REG_BITS-1:0] sync_pattern;
  } cfg_t;

endpackage

FILE: rtl/mqse_apb.sv
module mqse_apb import mqse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [REG_BITS-1:0] step_q;
  logic [REG_BITS-1:0] pattern_q;
  logic                wr_en;
  reg_idx_e            idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_RST;
      pattern_q <= PATTERN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_STEP:    step_q    <= pwdata[REG_BITS-1:0];
        REG_PATTERN: pattern_q <= pwdata[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STEP:    prdata = {{(32-REG_BITS){1'b0}}, step_q};
      REG_PATTERN: prdata = {{(32-REG_BITS){1'b0}}, pattern_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.step_size    = step_q;
  assign cfg_o.sync_pattern = pattern_q;

endmodule

FILE: rtl/mqse_div.sv
module mqse_div import mqse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o
);

  logic [DIV_W-1:0]  quo_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  dvs_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              done_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DCNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/mean_quantization_sync_embed.sv
// Mean-quantization sync embedder.
// Input channel (in_valid_i / in_stall_o / in_word_i) takes one audio sample per
// word; output channel (out_valid_o / out_stall_i / out_word_o) returns the
// adjusted samples of each finished group in arrival order, group_last on the
// final one. Config is an APB-style port: step_size at 0x0, sync_pattern at 0x4.
// While a group fills, a sample is taken every cycle. The word that completes a
// group stalls the input for the group's processing: the step product, then two
// passes through one bit-serial divider of DIV_W bits (group mean quantization,
// then the rounded offset); after that the adjusted words follow one per cycle
// while the output is not stalled. A stalled output holds its word and the
// emission pauses; input stays stalled until the last word of the group is
// loaded into the output register.
// region_start drops a partly filled group and restarts the sync pattern at bit 0.
// Reset restores the default register values and clears the fill count and the
// pattern position; no clearing pass is needed.
module mean_quantization_sync_embed import mqse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [7:0] {
    ST_FILL   = 8'b0000_0001,
    ST_MUL    = 8'b0000_0010,
    ST_QSTART = 8'b0000_0100,
    ST_QWAIT  = 8'b0000_1000,
    ST_XCALC  = 8'b0001_0000,
    ST_OSTART = 8'b0010_0000,
    ST_OWAIT  = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  localparam logic signed [X_W:0] SAT_MAX = (X_W+1)'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [X_W:0] SAT_MIN = -(X_W+1)'(2 ** (SAMPLE_BITS - 1));

  cfg_t cfg;

  state_e state_q, state_d;

  logic [FILL_W-1:0]             fill_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [POS_W-1:0]              pos_q;
  logic signed [SAMPLE_BITS-1:0] buf_q [GROUP_LEN];
  logic [ND_W-1:0]               nd_q;
  logic [ND_W-1:0]               r_q;
  logic                          match_q;
  logic signed [X_W-1:0]         x_q;
  logic signed [X_W-1:0]         off_q;
  logic [FILL_W-1:0]             emit_q;
  logic                          out_valid_q;
  out_word_t                     out_word_q;

  logic                   in_acc;
  logic [FILL_W-1:0]      fill_base;
  logic signed [SUM_W-1:0] sum_base;
  logic signed [SUM_W-1:0] sum_new;
  logic                   grp_done;

  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [DIV_W-1:0]       div_dividend;
  logic [DIV_W-1:0]       div_divisor;
  logic [DIV_W-1:0]       div_quo;
  logic [DIV_W-1:0]       div_rem;
  logic                   rem_nz;

  logic signed [X_W-1:0]  sum_x;
  logic signed [X_W-1:0]  sum_mag;
  logic signed [X_W-1:0]  x_mag;
  logic signed [X_W-1:0]  nd_x;
  logic signed [X_W-1:0]  r2_x;
  logic signed [X_W-1:0]  quo_x;
  logic [REG_BITS-1:0]    step_eff;

  logic                   emit_go;
  logic                   emit_last;
  logic signed [X_W:0]    adj;
  logic signed [X_W:0]    adj_sat;

  mqse_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mqse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  // input side
  assign in_stall_o = (state_q != ST_FILL);
  assign in_acc     = in_valid_i && (state_q == ST_FILL);
  assign fill_base  = in_word_i.region_start ? '0 : fill_q;
  assign sum_base   = (in_word_i.region_start || (fill_q == '0)) ? '0 : sum_q;
  assign sum_new    = sum_base + SUM_W'(in_word_i.sample_in);
  assign grp_done   = (fill_base == FILL_W'(GROUP_LEN - 1));

  // divider operands: first |sum| / (N*D), then |x| / (2N)
  assign sum_x     = X_W'(sum_q);
  assign sum_mag   = sum_x[X_W-1] ? -sum_x : sum_x;
  assign x_mag     = x_q[X_W-1] ? -x_q : x_q;
  assign div_start = (state_q == ST_QSTART) || (state_q == ST_OSTART);
  assign div_dividend = (state_q == ST_QSTART) ? sum_mag[DIV_W-1:0] : x_mag[DIV_W-1:0];
  assign div_divisor  = (state_q == ST_QSTART) ? DIV_W'(nd_q) : DIV_W'(2 * GROUP_LEN);
  assign rem_nz    = (div_rem != '0);

  assign step_eff = (cfg.step_size == '0) ? REG_BITS'(1) : cfg.step_size;
  assign nd_x     = signed'(X_W'(nd_q));
  assign r2_x     = signed'(X_W'({r_q, 1'b0}));
  assign quo_x    = signed'(X_W'(div_quo));

  // output side
  assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign emit_last = (emit_q == FILL_W'(GROUP_LEN - 1));
  assign adj       = (X_W+1)'(buf_q[0]) + (X_W+1)'(off_q);
  always_comb begin
    if (adj > SAT_MAX) begin
      adj_sat = SAT_MAX;
    end else if (adj < SAT_MIN) begin
      adj_sat = SAT_MIN;
    end else begin
      adj_sat = adj;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL:   if (in_acc && grp_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_QSTART;
      ST_QSTART: state_d = ST_QWAIT;
      ST_QWAIT:  if (div_done) state_d = ST_XCALC;
      ST_XCALC:  state_d = ST_OSTART;
      ST_OSTART: state_d = ST_OWAIT;
      ST_OWAIT:  if (div_done) state_d = ST_EMIT;
      ST_EMIT:   if (emit_go && emit_last) state_d = ST_FILL;
      default:   state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_q      <= '0;
      pos_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        fill_q <= grp_done ? '0 : fill_base + FILL_W'(1);
        if (in_word_i.region_start) begin
          pos_q <= '0;
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
        emit_q      <= emit_last ? '0 : emit_q + FILL_W'(1);
        if (emit_last) begin
          pos_q <= (pos_q == POS_W'(PATTERN_LEN - 1)) ? '0 : pos_q + POS_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_q <= sum_new;
    end
    // group buffer is a shift line: fill at the top, emit from the bottom
    if (in_acc || emit_go) begin
      for (int i = 0; i < GROUP_LEN - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[GROUP_LEN-1] <= in_word_i.sample_in;
    end
    if (state_q == ST_MUL) begin
      nd_q <= ND_W'(step_eff) * ND_W'(GROUP_LEN);
    end
    if ((state_q == ST_QWAIT) && div_done) begin
      // floor remainder and parity of floor(sum / (N*D))
      r_q     <= (sum_q[SUM_W-1] && rem_nz) ? nd_q - div_rem[ND_W-1:0]
                                            : div_rem[ND_W-1:0];
      match_q <= (div_quo[0] ^ (sum_q[SUM_W-1] && rem_nz)) == cfg.sync_pattern[pos_q];
    end
    if (state_q == ST_XCALC) begin
      x_q <= (match_q ? nd_x : -nd_x) - r2_x + X_W'(GROUP_LEN);
    end
    if ((state_q == ST_OWAIT) && div_done) begin
      off_q <= x_q[X_W-1] ? (rem_nz ? ~quo_x : -quo_x) : quo_x;
    end
    if (emit_go) begin
      out_word_q.sample_out <= adj_sat[SAMPLE_BITS-1:0];
      out_word_q.group_last <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_fill_clear_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (fill_q == '0))
    else $error("fill count not cleared during emission");

  a_stalled_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

  a_stall_release_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(state_q == ST_EMIT))
    else $error("input released before group delivered");

endmodule

FILE: test/mqse_embed_checker.sv
`timescale 1ns / 1ps
module mqse_embed_checker import mqse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_word_t          in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_word_t         out_word_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o
);

  localparam longint SAT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  logic [REG_BITS-1:0]           step_q;
  logic [REG_BITS-1:0]           pattern_q;
  logic signed [SAMPLE_BITS-1:0] group_q [GROUP_LEN];
  int                            fill_q;
  int                            pos_q;
  longint                        sum_q;
  out_word_t                     adjusted_q [$];
  int                            mismatches;

  function automatic longint floor_div(input longint a, input longint b);
    longint r;
    r = a / b;
    if ((a % b) != 0 && a < 0) r = r - 1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    longint                        d;
    longint                        q;
    longint                        twice_tgt;
    longint                        off;
    longint                        v;
    logic                          sync_bit;
    logic signed [SAMPLE_BITS-1:0] smp;
    out_word_t                     want;
    out_word_t                     got;
    if (!rst_ni) begin
      step_q     = STEP_RST;
      pattern_q  = PATTERN_RST;
      fill_q     = 0;
      sum_q      = 0;
      pos_q      = 0;
      mismatches = 0;
      adjusted_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_STEP: begin
            step_q = pwdata[REG_BITS-1:0];
          end
          REG_PATTERN: begin
            pattern_q = pwdata[REG_BITS-1:0];
          end
          default: begin
          end
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = out_word_i;
        if (adjusted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word: sample %0d last %0b",
                     got.sample_out, got.group_last);
        end else begin
          want = adjusted_q.pop_front();
          if (got.sample_out !== want.sample_out || got.group_last !== want.group_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: sample exp %0d got %0d, last exp %0b got %0b",
                       want.sample_out, got.sample_out, want.group_last, got.group_last);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.region_start) begin
          fill_q = 0;
          sum_q  = 0;
          pos_q  = 0;
        end
        smp = in_word_i.sample_in;
        group_q[fill_q] = smp;
        sum_q = sum_q + smp;
        fill_q++;
        if (fill_q == GROUP_LEN) begin
          // zero step behaves as one lsb
          d = (step_q == '0) ? 64'sd1 : longint'(step_q);
          q = floor_div(sum_q, GROUP_LEN * d);
          sync_bit = pattern_q[pos_q];
          twice_tgt = 2 * q * d + ((q[0] == sync_bit) ? d : -d);
          // target minus mean, rounded half up
          off = floor_div(GROUP_LEN * twice_tgt - 2 * sum_q + GROUP_LEN, 2 * GROUP_LEN);
          for (int k = 0; k < GROUP_LEN; k++) begin
            v = group_q[k] + off;
            if (v > SAT_MAX) v = SAT_MAX;
            if (v < SAT_MIN) v = SAT_MIN;
            want.sample_out = v[SAMPLE_BITS-1:0];
            want.group_last = (k == GROUP_LEN - 1);
            adjusted_q = {adjusted_q, want};
          end
          fill_q = 0;
          sum_q  = 0;
          pos_q  = (pos_q + 1) % PATTERN_LEN;
        end
      end
    end
    fail_count_o = mismatches;
    pending_o    = adjusted_q.size();
  end

endmodule

FILE: test/mean_quantization_sync_embed_tb.sv
`timescale 1ns / 1ps
module mean_quantization_sync_embed_tb;
  import mqse_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 2 * DIV_W + 16;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 55;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  in_word_t          in_word_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  out_word_t         out_word_o;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  bit idle_on      = 1'b1;
  bit hold_req     = 1'b0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  mean_quantization_sync_embed u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  mqse_embed_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[mean_quantization_sync_embed] ERROR");
      $finish;
    end
  end

  // output side: random stall bursts, or one long hold on request
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp, input logic restart);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= '{sample_in: smp, region_start: restart};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [REG_BITS-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle_all();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int                            ph;
    int                            i;
    logic signed [SAMPLE_BITS-1:0] s;
    logic signed [SAMPLE_BITS-1:0] base;
    logic                          restart;
    logic [REG_BITS-1:0]           stp;
    logic [REG_BITS-1:0]           pat;
    base = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: full-scale groups, a dropped partial group, mixed extremes
    send_word(16'sh7fff, 1'b1);
    repeat (4) send_word(16'sh7fff, 1'b0);
    repeat (5) send_word(16'sh8000, 1'b0);
    send_word(16'sh1234, 1'b0);
    send_word(16'shffff, 1'b0);
    send_word(16'sh0000, 1'b0);
    // restart mid group drops the three words above
    send_word(16'sh0100, 1'b1);
    repeat (4) send_word(16'sh0100, 1'b0);
    send_word(16'sh0001, 1'b0);
    send_word(16'shffff, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b0);
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      settle_all();
      case (ph)
        0: begin
          stp = 16'd1;
          pat = 16'h0000;
        end
        1: begin
          stp = 16'hffff;
          pat = 16'hffff;
        end
        2: begin
          stp = 16'd0;
          pat = 16'($urandom);
        end
        3: begin
          stp = 16'($urandom_range(1, 64));
          pat = 16'($urandom);
        end
        4: begin
          stp = 16'($urandom_range(1, 65535));
          pat = 16'($urandom);
        end
        default: begin
          stp = STEP_RST;
          pat = PATTERN_RST;
        end
      endcase
      cfg_write(REG_STEP, stp);
      cfg_write(REG_PATTERN, pat);
      idle_on = (ph < PHASES - 1);
      if (ph == 1) hold_req = 1'b1;
      for (i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 3 && i == PHASE_WORDS / 2) begin
          // sender holds back until every adjusted word is out
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        if (i % GROUP_LEN == 0) base = 16'($urandom);
        case ($urandom_range(0, 7))
          0: s = 16'($urandom);
          1: s = 16'sh7fff - 16'($urandom_range(0, 200));
          2: s = 16'sh8000 + 16'($urandom_range(0, 200));
          default: s = base + 16'($urandom_range(0, 511)) - 16'sd256;
        endcase
        // restarts only in some phases so the sync pattern also wraps
        restart = (ph == 2 || ph == 4) && ($urandom_range(0, 29) == 0);
        send_word(s, restart);
      end
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end

    settle_all();
    if (fail_count == 0 && pending == 0)
      $display("[mean_quantization_sync_embed] OK");
    else
      $display("[mean_quantization_sync_embed] ERROR");
    $finish;
  end

endmodule
